/* hdl/ip_to_mac_binding_table_with_aging_macros.svh */
// assertion macros for the ip to mac binding table
`ifndef IP_TO_MAC_BINDING_TABLE_WITH_AGING_MACROS_SVH
`define IP_TO_MAC_BINDING_TABLE_WITH_AGING_MACROS_SVH

// same-cycle implication, sampled on clk, off during reset
`define IPMAC_ASSERT_IMPL(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |-> (post)) \
		else $error(msg);

// next-cycle implication, sampled on clk, off during reset
`define IPMAC_ASSERT_NEXT(lbl, pre, post, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (pre) |=> (post)) \
		else $error(msg);

`endif

/* hdl/ipmac_pkg.sv */
// types, codes and control store of the ip to mac binding table
package ipmac_pkg;

	// operation codes of an item
	typedef enum logic [2:0] {
		OP_TICK   = 3'd0,
		OP_LEARN  = 3'd1,
		OP_LOOKUP = 3'd2,
		OP_SWEEP  = 3'd3,
		OP_FLUSH  = 3'd4
	} op_t;

	// configuration register indexes
	typedef enum logic [1:0] {
		REG_ENABLE  = 2'd0,
		REG_START   = 2'd1,
		REG_END     = 2'd2,
		REG_TIMEOUT = 2'd3
	} reg_idx_t;

	localparam int unsigned CFG_W = 32;

	// one binding
	typedef struct packed {
		logic        valid;
		logic [31:0] ip;
		logic [47:0] mac;
		logic [31:0] last;
	} entry_t;

	// program steps
	typedef enum logic [2:0] {
		UC_IDLE  = 3'd0,
		UC_SCAN  = 3'd1,
		UC_DRAIN = 3'd2,
		UC_WBACK = 3'd3,
		UC_DONE  = 3'd4
	} step_t;

	// jump kinds
	typedef enum logic [1:0] {
		J_WAIT = 2'd0,
		J_NEXT = 2'd1,
		J_GOTO = 2'd2,
		J_LOOP = 2'd3
	} jump_t;

	// one control word
	typedef struct packed {
		jump_t jmp;
		step_t target;
		logic  rd;
		logic  wb;
		logic  done;
	} uc_word_t;

	// control store
	function automatic uc_word_t uc_rom(step_t step);
		uc_word_t w;
		w = '{jmp: J_GOTO, target: UC_IDLE, rd: 1'b0, wb: 1'b0, done: 1'b0};
		unique case (step)
			UC_IDLE:  w = '{jmp: J_WAIT, target: UC_IDLE, rd: 1'b0, wb: 1'b0, done: 1'b0};
			UC_SCAN:  w = '{jmp: J_LOOP, target: UC_SCAN, rd: 1'b1, wb: 1'b0, done: 1'b0};
			UC_DRAIN: w = '{jmp: J_NEXT, target: UC_IDLE, rd: 1'b0, wb: 1'b0, done: 1'b0};
			UC_WBACK: w = '{jmp: J_NEXT, target: UC_IDLE, rd: 1'b0, wb: 1'b1, done: 1'b0};
			UC_DONE:  w = '{jmp: J_GOTO, target: UC_IDLE, rd: 1'b0, wb: 1'b0, done: 1'b1};
			default:  w = '{jmp: J_GOTO, target: UC_IDLE, rd: 1'b0, wb: 1'b0, done: 1'b0};
		endcase
		return w;
	endfunction

endpackage

/* hdl/ip_to_mac_binding_table_with_aging.sv */
// ip to mac binding table with aging, microcoded scan over a 1R1W table memory
//
// An item is taken when start is high and busy is low; its single result shows on
// the result ports for exactly one cycle, flagged by done, and cannot be held off.
// Learn, lookup (outside the translated range), sweep and flush walk the whole
// table memory one entry per cycle, then pass a drain, a write-back and a done
// step, and busy stays high until the done step is over; the walk over the
// single read port of the memory sets the length of such an item. Ticks, unused
// codes, and learn, lookup or sweep with translation off (or lookup inside the
// range) go straight from idle to the done step. After reset the block runs a
// clearing pass over the memory with busy high and no result; configuration
// writes are taken during it. Configuration is to be written only while the
// block is idle; the block itself does not enforce this.
`include "ip_to_mac_binding_table_with_aging_macros.svh"

module ip_to_mac_binding_table_with_aging
	import ipmac_pkg::*;
#(
	parameter int TABLE_ENTRIES           = 16,
	parameter int TICKS_PER_SECOND        = 100,
	parameter int DEFAULT_TIMEOUT_SECONDS = 120
) (
	input  logic              clk,
	input  logic              arst_n,
	// item channel
	input  logic              start,
	output logic              busy,
	input  logic [2:0]        operation,
	input  logic [31:0]       ip_address,
	input  logic [47:0]       mac_address,
	// result channel
	output logic              done,
	output logic              hit,
	output logic              rewrite,
	output logic [47:0]       mac_result,
	output logic              in_range,
	output logic              table_full,
	output logic [4:0]        removed_count,
	// configuration write port
	input  logic              cfg_write,
	input  logic [1:0]        cfg_index,
	input  logic [CFG_W-1:0]  cfg_data
);

	localparam int IW = (TABLE_ENTRIES > 1) ? $clog2(TABLE_ENTRIES) : 1;
	localparam logic [IW-1:0] LAST_IDX = IW'(TABLE_ENTRIES - 1);
	localparam logic [15:0]   DEF_SECS = 16'(DEFAULT_TIMEOUT_SECONDS);

	// configuration registers
	logic        enable_q;
	logic [31:0] start_q;
	logic [31:0] end_q;
	logic [15:0] timeout_q;

	// sequencer
	step_t       step_q, step_d, disp_step;
	uc_word_t    uc;
	logic        clearing_q;     // reset clearing pass in progress
	logic        accept;

	// item registers
	op_t         op_q;
	logic [31:0] ip_q;
	logic [47:0] mac_q;
	logic [31:0] now_q;
	logic [31:0] tmo_q;
	logic        inr_q;

	// scan datapath
	logic [IW-1:0] idx_q;
	logic          last_idx;
	logic          ev_s1;        // read data valid for evaluation
	logic [IW-1:0] eidx_s1;
	entry_t        rd_s1;

	logic          found_q;
	logic [IW-1:0] found_idx_q;
	logic [47:0]   found_mac_q;
	logic          have_free_q;
	logic [IW-1:0] free_idx_q;
	logic          full_q;
	logic [4:0]    cnt_q;

	// table memory
	entry_t        tbl_q [TABLE_ENTRIES];
	logic          mem_we;
	logic [IW-1:0] mem_waddr;
	entry_t        mem_wdata;

	// dispatch side
	op_t         op_in;
	logic        inr_in;
	logic [15:0] secs_in;
	logic [31:0] tmo_in;

	// evaluation of the entry read last cycle
	logic        ev_live;
	logic        ev_match;
	logic        ev_free;
	logic        ev_expire;
	logic        ev_flush;
	logic [31:0] age_d;

	assign accept   = start && !busy;
	assign busy     = (step_q != UC_IDLE);
	assign last_idx = (idx_q == LAST_IDX);

	assign op_in   = op_t'(operation);
	assign inr_in  = enable_q && (op_in == OP_LEARN || op_in == OP_LOOKUP)
		&& (ip_address >= start_q) && (ip_address <= end_q);
	assign secs_in = (timeout_q == 16'd0) ? DEF_SECS : timeout_q;
	assign tmo_in  = 32'(32'(secs_in) * 32'(TICKS_PER_SECOND));

	// control word of the current step
	always_comb begin
		uc = uc_rom(step_q);
	end

	// first step of an item's program
	always_comb begin
		disp_step = UC_DONE;
		case (op_in) inside
			OP_LEARN, OP_SWEEP: disp_step = enable_q ? UC_SCAN : UC_DONE;
			OP_LOOKUP:          disp_step = (enable_q && !inr_in) ? UC_SCAN : UC_DONE;
			OP_FLUSH:           disp_step = UC_SCAN;
			default:            disp_step = UC_DONE;
		endcase
	end

	// next step
	always_comb begin
		step_d = step_q;
		unique case (uc.jmp)
			J_WAIT: if (accept) begin
				step_d = disp_step;
			end
			J_NEXT: step_d = step_t'(3'(step_q) + 3'd1);
			J_GOTO: step_d = uc.target;
			J_LOOP: step_d = last_idx ? step_t'(3'(step_q) + 3'd1) : uc.target;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q     <= UC_SCAN;
			clearing_q <= 1'b1;
		end else begin
			step_q <= step_d;
			if (uc.done) begin
				clearing_q <= 1'b0;
			end
		end
	end

	// configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			enable_q  <= 1'b0;
			start_q   <= '0;
			end_q     <= '0;
			timeout_q <= '0;
		end else if (cfg_write) begin
			unique case (reg_idx_t'(cfg_index))
				REG_ENABLE:  enable_q  <= cfg_data[0];
				REG_START:   start_q   <= cfg_data[31:0];
				REG_END:     end_q     <= cfg_data[31:0];
				REG_TIMEOUT: timeout_q <= cfg_data[15:0];
			endcase
		end
	end

	// item capture and tick counter
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			now_q <= '0;
			inr_q <= 1'b0;
		end else if (accept) begin
			inr_q <= inr_in;
			if (op_in == OP_TICK) begin
				now_q <= now_q + 32'd1;
			end
		end
	end

	// payload of the item, no reset needed
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q  <= op_in;
			ip_q  <= ip_address;
			mac_q <= mac_address;
			tmo_q <= tmo_in;
		end
	end

	// evaluation of one entry
	assign ev_live   = ev_s1 && !clearing_q;
	assign age_d     = rd_s1.last + tmo_q - now_q;
	assign ev_match  = ev_live && rd_s1.valid && (rd_s1.ip == ip_q)
		&& (op_q == OP_LEARN || op_q == OP_LOOKUP);
	assign ev_free   = ev_live && !rd_s1.valid && (op_q == OP_LEARN);
	// expired when now lies past last use plus timeout, by the sign of the difference
	assign ev_expire = ev_live && (op_q == OP_SWEEP) && rd_s1.valid && age_d[31];
	assign ev_flush  = ev_live && (op_q == OP_FLUSH) && rd_s1.valid;

	// scan index, read pipeline and search results
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			ev_s1       <= 1'b0;
			eidx_s1     <= '0;
			found_q     <= 1'b0;
			found_idx_q <= '0;
			have_free_q <= 1'b0;
			free_idx_q  <= '0;
			full_q      <= 1'b0;
			cnt_q       <= '0;
		end else begin
			ev_s1   <= uc.rd;
			eidx_s1 <= idx_q;
			if (uc.rd) begin
				idx_q <= last_idx ? '0 : idx_q + IW'(1);
			end
			if (accept) begin
				found_q     <= 1'b0;
				have_free_q <= 1'b0;
				full_q      <= 1'b0;
				cnt_q       <= '0;
			end else begin
				// first match and first free entry win
				if (ev_match && !found_q) begin
					found_q     <= 1'b1;
					found_idx_q <= eidx_s1;
				end
				if (ev_free && !have_free_q) begin
					have_free_q <= 1'b1;
					free_idx_q  <= eidx_s1;
				end
				if ((ev_expire || ev_flush) && cnt_q != 5'd31) begin
					cnt_q <= cnt_q + 5'd1;
				end
				if (uc.wb && !clearing_q && op_q == OP_LEARN && !found_q && !have_free_q) begin
					full_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ev_match && !found_q) begin
			found_mac_q <= rd_s1.mac;
		end
	end

	// memory write port: scan removals and the clearing pass, or the write-back step
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = eidx_s1;
		mem_wdata = '0;
		if (ev_s1 && (clearing_q || ev_expire || ev_flush)) begin
			mem_we = 1'b1;
		end else if (uc.wb && !clearing_q) begin
			mem_wdata = '{valid: 1'b1, ip: ip_q,
				mac: (op_q == OP_LEARN) ? mac_q : found_mac_q, last: now_q};
			if (found_q && (op_q == OP_LEARN || op_q == OP_LOOKUP)) begin
				mem_we    = 1'b1;
				mem_waddr = found_idx_q;
			end else if (have_free_q && op_q == OP_LEARN) begin
				mem_we    = 1'b1;
				mem_waddr = free_idx_q;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			tbl_q[mem_waddr] <= mem_wdata;
		end
		if (uc.rd) begin
			rd_s1 <= tbl_q[idx_q];
		end
	end

	// result, valid in the done step
	assign done          = uc.done && !clearing_q;
	assign hit           = found_q;
	assign rewrite       = found_q && (op_q == OP_LOOKUP);
	assign mac_result    = rewrite ? found_mac_q : 48'd0;
	assign in_range      = inr_q;
	assign table_full    = full_q;
	assign removed_count = cnt_q;

	`IPMAC_ASSERT_IMPL(a_done_busy, done, busy, "result strobe while not busy")
	`IPMAC_ASSERT_NEXT(a_accept_busy, start && !busy, busy, "taken item did not raise busy")
	`IPMAC_ASSERT_IMPL(a_rewrite_hit, done && rewrite, hit && !table_full, "rewrite without hit")
	`IPMAC_ASSERT_IMPL(a_mac_zero, done && !rewrite, mac_result == 48'd0, "mac without rewrite")
	`IPMAC_ASSERT_IMPL(a_write_excl, ev_s1, !uc.wb, "scan write meets write-back")

endmodule
